// ----- src/pwv_pkg.sv -----
package pwv_pkg;

   // hash and gust constants
   localparam logic [31:0] HASH_XOR   = 32'd61;
   localparam logic [31:0] HASH_MUL   = 32'h27d4eb2d;
   localparam logic [31:0] FRAME_STEP = 32'd7919;
   localparam logic [31:0] HASH_MAX   = 32'h7FFFFFFF;
   localparam logic [17:0] GUST_ONE   = 18'd65536;
   localparam logic [16:0] GUST_LIMIT = 17'd65536;

   // delta = round(p / (100 * 2^28)): bias, shift by 28, then times ceil(2^31 / 100)
   localparam logic [51:0] ROUND_BIAS = 52'd13421772800;
   localparam logic [24:0] RECIP_100  = 25'd21474837;

   localparam logic [17:0] UNIT_MAX       = 18'd131071;
   localparam logic [16:0] DIR_X_RESET    = 17'd4096;
   localparam logic [15:0] STRENGTH_RESET = 16'd4096;
   localparam logic [32:0] US_X_RESET     = 33'd268435456;

   localparam int ROOT_STEPS = 25;
   localparam int DIV_STEPS  = 18;
   localparam int MID_DEPTH  = 4;
   localparam int OUT_DEPTH  = 16;

   typedef enum logic [2:0] {
      CSR_DIR_X    = 3'd0,
      CSR_DIR_Y    = 3'd1,
      CSR_DIR_Z    = 3'd2,
      CSR_STRENGTH = 3'd3,
      CSR_GUST     = 3'd4,
      CSR_FRAME    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SQUARE,
      CS_ROOT,
      CS_PREP,
      CS_DIVIDE,
      CS_SCALE
   } cfg_state_type;

   // per-lane |unit| * strength and sign, plus gust amount, frame product and active flag
   typedef struct packed {
      logic [2:0][32:0] us_mag;
      logic [2:0]       us_neg;
      logic [16:0]      gust_amt;
      logic [31:0]      frame_mul;
      logic             active;
   } cfg_type;

endpackage

// ----- src/pwv_fifo.sv -----
module pwv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/pwv_config.sv -----
module pwv_config (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output pwv_pkg::cfg_type cfg,
   output logic             busy
);

   import pwv_pkg::*;

   logic [2:0][16:0] dir_ff, dir_in;
   logic [15:0]      strength_ff, strength_in;
   logic [16:0]      gust_ff, gust_in;
   logic [31:0]      frame_ff, frame_in, frame_mul_ff;
   cfg_state_type    state_ff, state_in;
   logic [1:0]       comp_ff, comp_in;
   logic [4:0]       step_ff, step_in;
   logic [33:0]      sum_ff, sum_in;
   logic [49:0]      rad_ff, rad_in;
   logic [25:0]      rem_ff, rem_in;
   logic [24:0]      root_ff, root_in;
   logic [17:0]      nbits_ff, nbits_in;
   logic [24:0]      drem_ff, drem_in;
   logic [17:0]      quo_ff, quo_in;
   logic [2:0][32:0] us_mag_ff, us_mag_in;
   logic [2:0]       us_neg_ff, us_neg_in;
   logic             active_ff, active_in;

   logic        wr_hit;
   logic [16:0] dir_abs, ua, mul_a, mul_b;
   logic [33:0] mul_p, sum_next;
   logic [27:0] rem_shift, trial;
   logic [40:0] num;
   logic [25:0] dtrial;

   assign wr_hit  = csr_wen && (csr_index <= CSR_FRAME);
   assign dir_abs = dir_ff[comp_ff][16] ? (~dir_ff[comp_ff] + 17'd1) : dir_ff[comp_ff];
   assign ua      = (quo_ff > UNIT_MAX) ? UNIT_MAX[16:0] : quo_ff[16:0];
   // one multiplier serves the squares and the strength scaling
   assign mul_a   = (state_ff == CS_SCALE) ? ua : dir_abs;
   assign mul_b   = (state_ff == CS_SCALE) ? {1'b0, strength_ff} : dir_abs;
   assign mul_p   = 34'(mul_a) * 34'(mul_b);
   assign sum_next  = sum_ff + mul_p;
   assign rem_shift = {rem_ff, rad_ff[49:48]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign num       = {dir_abs, 24'd0} + 41'(root_ff >> 1);
   assign dtrial    = {drem_ff, nbits_ff[17]};

   always_comb begin
      dir_in      = dir_ff;
      strength_in = strength_ff;
      gust_in     = gust_ff;
      frame_in    = frame_ff;
      state_in    = state_ff;
      comp_in     = comp_ff;
      step_in     = step_ff;
      sum_in      = sum_ff;
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      nbits_in    = nbits_ff;
      drem_in     = drem_ff;
      quo_in      = quo_ff;
      us_mag_in   = us_mag_ff;
      us_neg_in   = us_neg_ff;
      active_in   = active_ff;

      case (state_ff)
         CS_IDLE: begin
         end
         CS_SQUARE: begin
            sum_in  = sum_next;
            comp_in = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               comp_in = '0;
               if (sum_next == '0) begin
                  us_mag_in = '0;
                  us_neg_in = '0;
                  active_in = 1'b0;
                  state_in  = CS_IDLE;
               end else begin
                  rad_in   = {sum_next, 16'd0};
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = '0;
                  state_in = CS_ROOT;
               end
            end
         end
         CS_ROOT: begin
            // two radicand bits per step
            if (rem_shift >= trial) begin
               rem_in  = 26'(rem_shift - trial);
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in  = 26'(rem_shift);
               root_in = {root_ff[23:0], 1'b0};
            end
            rad_in  = {rad_ff[47:0], 2'b00};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(ROOT_STEPS - 1)) begin
               comp_in  = '0;
               state_in = CS_PREP;
            end
         end
         CS_PREP: begin
            // quotient fits 18 bits since len >= 256 * |d|
            drem_in  = 25'(num[40:18]);
            nbits_in = num[17:0];
            quo_in   = '0;
            step_in  = '0;
            state_in = CS_DIVIDE;
         end
         CS_DIVIDE: begin
            if (dtrial >= {1'b0, root_ff}) begin
               drem_in = 25'(dtrial - {1'b0, root_ff});
               quo_in  = {quo_ff[16:0], 1'b1};
            end else begin
               drem_in = dtrial[24:0];
               quo_in  = {quo_ff[16:0], 1'b0};
            end
            nbits_in = {nbits_ff[16:0], 1'b0};
            step_in  = step_ff + 5'd1;
            if (step_ff == 5'(DIV_STEPS - 1)) begin
               state_in = CS_SCALE;
            end
         end
         CS_SCALE: begin
            us_mag_in[comp_ff] = mul_p[32:0];
            us_neg_in[comp_ff] = dir_ff[comp_ff][16];
            if (comp_ff == 2'd2) begin
               comp_in   = '0;
               active_in = (strength_ff != '0);
               state_in  = CS_IDLE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = CS_PREP;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase

      // any write to a defined register restarts the recompute from the new values
      if (wr_hit) begin
         case (csr_index)
            CSR_DIR_X:    dir_in[0]   = csr_wdata[16:0];
            CSR_DIR_Y:    dir_in[1]   = csr_wdata[16:0];
            CSR_DIR_Z:    dir_in[2]   = csr_wdata[16:0];
            CSR_STRENGTH: strength_in = csr_wdata[15:0];
            CSR_GUST:     gust_in     = csr_wdata[16:0];
            CSR_FRAME:    frame_in    = csr_wdata;
            default: begin
            end
         endcase
         state_in = CS_SQUARE;
         comp_in  = '0;
         sum_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= {17'd0, 17'd0, DIR_X_RESET};
         strength_ff  <= STRENGTH_RESET;
         gust_ff      <= '0;
         frame_ff     <= '0;
         frame_mul_ff <= '0;
         state_ff     <= CS_IDLE;
         comp_ff      <= '0;
         us_mag_ff    <= {33'd0, 33'd0, US_X_RESET};
         us_neg_ff    <= '0;
         active_ff    <= 1'b1;
      end else begin
         dir_ff       <= dir_in;
         strength_ff  <= strength_in;
         gust_ff      <= gust_in;
         frame_ff     <= frame_in;
         frame_mul_ff <= frame_ff * FRAME_STEP;
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         us_mag_ff    <= us_mag_in;
         us_neg_ff    <= us_neg_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      sum_ff   <= sum_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      nbits_ff <= nbits_in;
      drem_ff  <= drem_in;
      quo_ff   <= quo_in;
   end

   always_comb begin
      cfg.us_mag    = us_mag_ff;
      cfg.us_neg    = us_neg_ff;
      cfg.gust_amt  = (gust_ff > GUST_LIMIT) ? GUST_LIMIT : gust_ff;
      cfg.frame_mul = frame_mul_ff;
      cfg.active    = active_ff;
   end

   assign busy = (state_ff != CS_IDLE);

   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      wr_hit |=> busy)
      else $error("register write did not start recompute");

   a_active_strength: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_IDLE && active_ff) |-> (strength_ff != '0))
      else $error("force active with zero strength");

endmodule

// ----- src/pwv_front.sv -----
module pwv_front #(
   parameter int VELOCITY_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [31:0]                          req_particle_index,
   input  logic [VELOCITY_WIDTH-1:0]            req_vel_x,
   input  logic [VELOCITY_WIDTH-1:0]            req_vel_y,
   input  logic [VELOCITY_WIDTH-1:0]            req_vel_z,
   input  pwv_pkg::cfg_type                     cfg,
   input  logic                                 cfg_busy,
   input  logic                                 mid_pop,
   output logic                                 mid_valid,
   output logic [32+3*VELOCITY_WIDTH:0]         mid_data
);

   import pwv_pkg::*;

   localparam int MID_W = 33 + 3 * VELOCITY_WIDTH;

   logic             mid_full, mid_empty, accept;
   logic [31:0]      seed;
   logic [MID_W-1:0] entry;

   // hash seed: index + frame * 7919, the product kept ready by the config block
   assign seed   = req_particle_index + cfg.frame_mul;
   assign entry  = {cfg.active, seed, req_vel_z, req_vel_y, req_vel_x};
   assign full   = mid_full || cfg_busy;
   assign accept = push && !full;

   pwv_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (entry),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .full      (mid_full),
      .empty     (mid_empty)
   );

   assign mid_valid = !mid_empty;

endmodule

// ----- src/pwv_back.sv -----
module pwv_back #(
   parameter int VELOCITY_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pwv_pkg::cfg_type                  cfg,
   input  logic                              mid_valid,
   input  logic [32+3*VELOCITY_WIDTH:0]      mid_data,
   output logic                              mid_pop,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [VELOCITY_WIDTH-1:0]  rsp_new_vel_x,
   output logic signed [VELOCITY_WIDTH-1:0]  rsp_new_vel_y,
   output logic signed [VELOCITY_WIDTH-1:0]  rsp_new_vel_z,
   output logic                              rsp_saturated
);

   import pwv_pkg::*;

   localparam int VW       = VELOCITY_WIDTH;
   localparam int MID_W    = 33 + 3 * VW;
   localparam int OUT_W    = 3 * VW + 1;
   localparam int SW       = VW + 20;
   localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

   logic [CREDIT_W-1:0] credits_ff, credits_in;
   logic                issue, take, out_full;

   logic [7:1]             pipe_v_ff;
   logic [7:1]             act_ff;
   logic [2:0][VW-1:0]     vel_ff [1:7];

   logic [31:0]       seed, h1, h2, h3, h5, twor;
   logic [31:0]       h3_ff, h4_ff;
   logic [30:0]       diff;
   logic              pos, pos_ff;
   logic [47:0]       gprod_ff;
   logic [48:0]       x2;
   logic [17:0]       qa, q, gust_ff, gust;
   logic [30:0]       qb;
   logic [31:0]       rsum;
   logic [18:0]       qm;
   logic [2:0][50:0]  p_ff;
   logic [2:0][23:0]  y_ff;
   logic [2:0][17:0]  mag_ff;
   logic [51:0]       yb [3];
   logic [48:0]       mp [3];
   logic [18:0]       dd [3];
   logic signed [SW-1:0] vsum [3];
   logic signed [SW-1:0] vmax_s, vmin_s;
   logic [2:0][VW-1:0]   nv;
   logic [2:0]           lane_sat;
   logic [OUT_W-1:0]     out_entry, out_data;

   // issue only against a free result slot, so the pipeline never stalls
   assign issue   = mid_valid && (credits_ff != '0);
   assign mid_pop = issue;
   assign take    = pop && !empty;
   assign credits_in = credits_ff - CREDIT_W'(issue) + CREDIT_W'(take);

   // stage 1: hash front half
   assign seed = mid_data[MID_W-2 -: 32];
   assign h1   = seed ^ HASH_XOR ^ (seed >> 16);
   assign h2   = h1 + (h1 << 3);
   assign h3   = h2 ^ (h2 >> 4);

   // stage 3: |2r - M| times gust amount
   assign h5   = h4_ff ^ (h4_ff >> 15);
   assign twor = {h5[30:0], 1'b0};
   assign pos  = (twor >= HASH_MAX);
   assign diff = pos ? 31'(twor - HASH_MAX) : 31'(HASH_MAX - twor);

   // stage 4: x / (2^31 - 1) as high part plus one correction, then halve
   assign x2   = {gprod_ff, 1'b0} + 49'(HASH_MAX);
   assign qa   = x2[48:31];
   assign qb   = x2[30:0];
   assign rsum = 32'(qa) + 32'(qb);
   assign qm   = 19'(qa) + ((rsum >= HASH_MAX) ? 19'd1 : 19'd0);
   assign q    = qm[18:1];
   assign gust = pos_ff ? (GUST_ONE + q) : (GUST_ONE - q);

   assign vmax_s = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
   assign vmin_s = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         yb[i] = 52'(p_ff[i]) + ROUND_BIAS;
         mp[i] = 49'(y_ff[i]) * 49'(RECIP_100);
         dd[i] = cfg.us_neg[i] ? (19'd0 - {1'b0, mag_ff[i]}) : {1'b0, mag_ff[i]};
         vsum[i] = {{(SW-VW){vel_ff[7][i][VW-1]}}, vel_ff[7][i]}
                 + {{(SW-19){dd[i][18]}}, dd[i]};
         if (!act_ff[7]) begin
            nv[i]       = vel_ff[7][i];
            lane_sat[i] = 1'b0;
         end else if (vsum[i] > vmax_s) begin
            nv[i]       = vmax_s[VW-1:0];
            lane_sat[i] = 1'b1;
         end else if (vsum[i] < vmin_s) begin
            nv[i]       = vmin_s[VW-1:0];
            lane_sat[i] = 1'b1;
         end else begin
            nv[i]       = vsum[i][VW-1:0];
            lane_sat[i] = 1'b0;
         end
      end
   end

   assign out_entry = {|lane_sat, nv};

   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff <= CREDIT_W'(OUT_DEPTH);
         pipe_v_ff  <= '0;
      end else begin
         credits_ff <= credits_in;
         pipe_v_ff  <= {pipe_v_ff[6:1], issue};
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= {act_ff[6:1], mid_data[MID_W-1]};
      vel_ff[1] <= mid_data[3*VW-1:0];
      for (int s = 2; s <= 7; s++) begin
         vel_ff[s] <= vel_ff[s-1];
      end
      h3_ff    <= h3;
      h4_ff    <= h3_ff * HASH_MUL;
      gprod_ff <= 48'(cfg.gust_amt) * 48'(diff);
      pos_ff   <= pos;
      gust_ff  <= gust;
      for (int i = 0; i < 3; i++) begin
         p_ff[i]   <= 51'(cfg.us_mag[i]) * 51'(gust_ff);
         y_ff[i]   <= yb[i][51:28];
         mag_ff[i] <= mp[i][48:31];
      end
   end

   pwv_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pipe_v_ff[7]),
      .push_data (out_entry),
      .pop       (pop),
      .pop_data  (out_data),
      .full      (out_full),
      .empty     (empty)
   );

   assign rsp_new_vel_x = out_data[VW-1:0];
   assign rsp_new_vel_y = out_data[2*VW-1:VW];
   assign rsp_new_vel_z = out_data[3*VW-1:2*VW];
   assign rsp_saturated = out_data[OUT_W-1];

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credits_ff <= CREDIT_W'(OUT_DEPTH))
      else $error("result credits above queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pipe_v_ff[7] |-> !out_full)
      else $error("result written into full queue");

endmodule

// ----- src/particle_wind_velocity_update.sv -----
// A request accepted by the front passes a queue hop, the 7-stage back pipeline and a result
// queue write before it can be popped as a result.
// Throughput: one request per cycle unless a recompute runs or no result slot is free; the
// 16-entry result queue covers the pipeline. A write to a defined register recomputes the unit
// direction with a serial square root and divider; full stays high until the recompute ends.
// Reset (synchronous): registers take their defaults, direction (1,0,0), queues empty.
module particle_wind_velocity_update #(
   parameter int VELOCITY_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [31:0]                       req_particle_index,
   input  logic signed [VELOCITY_WIDTH-1:0]  req_vel_x,
   input  logic signed [VELOCITY_WIDTH-1:0]  req_vel_y,
   input  logic signed [VELOCITY_WIDTH-1:0]  req_vel_z,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [VELOCITY_WIDTH-1:0]  rsp_new_vel_x,
   output logic signed [VELOCITY_WIDTH-1:0]  rsp_new_vel_y,
   output logic signed [VELOCITY_WIDTH-1:0]  rsp_new_vel_z,
   output logic                              rsp_saturated,
   input  logic                              csr_wen,
   input  logic [2:0]                        csr_index,
   input  logic [31:0]                       csr_wdata
);

   import pwv_pkg::*;

   cfg_type                         cfg;
   logic                            cfg_busy, mid_valid, mid_pop;
   logic [32+3*VELOCITY_WIDTH:0]    mid_data;

   pwv_config u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .busy      (cfg_busy)
   );

   pwv_front #(
      .VELOCITY_WIDTH (VELOCITY_WIDTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_particle_index (req_particle_index),
      .req_vel_x          (req_vel_x),
      .req_vel_y          (req_vel_y),
      .req_vel_z          (req_vel_z),
      .cfg                (cfg),
      .cfg_busy           (cfg_busy),
      .mid_pop            (mid_pop),
      .mid_valid          (mid_valid),
      .mid_data           (mid_data)
   );

   pwv_back #(
      .VELOCITY_WIDTH (VELOCITY_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .mid_valid     (mid_valid),
      .mid_data      (mid_data),
      .mid_pop       (mid_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_new_vel_x (rsp_new_vel_x),
      .rsp_new_vel_y (rsp_new_vel_y),
      .rsp_new_vel_z (rsp_new_vel_z),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ----- tb/sv/particle_wind_checker.sv -----
`timescale 1ns / 1ps

module particle_wind_checker #(
   parameter int VW = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic [31:0]           req_particle_index,
   input  logic [VW-1:0]         req_vel_x,
   input  logic [VW-1:0]         req_vel_y,
   input  logic [VW-1:0]         req_vel_z,
   input  logic                  empty,
   input  logic                  pop,
   input  logic [VW-1:0]         rsp_new_vel_x,
   input  logic [VW-1:0]         rsp_new_vel_y,
   input  logic [VW-1:0]         rsp_new_vel_z,
   input  logic                  rsp_saturated,
   input  logic                  csr_wen,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output int unsigned           failures,
   output int unsigned           waiting
);
   import pwv_pkg::*;

   localparam logic [31:0] SEED_XOR     = 32'd61;
   localparam logic [31:0] SEED_MUL     = 32'h27d4eb2d;
   localparam logic [31:0] FRAME_STRIDE = 32'd7919;
   localparam longint unsigned HALF_RANGE    = 64'h7FFF_FFFF;
   localparam longint unsigned GUST_UNITY    = 64'd65536;
   localparam longint unsigned FORCE_DIVISOR = 64'd100 << 28;
   localparam longint unsigned UNIT_CLAMP    = 64'd131071;
   localparam longint VEL_TOP    = (longint'(1) <<< (VW - 1)) - 1;
   localparam longint VEL_BOTTOM = -VEL_TOP - 1;

   typedef struct packed {
      logic [2:0][VW-1:0] vel;
      logic               sat;
   } wind_velocity_type;

   wind_velocity_type  expected_velocities[$];
   logic [2:0][16:0]   wind_dir;
   logic [15:0]        wind_strength;
   logic [16:0]        gust_amount;
   logic [31:0]        frame_number;
   longint             unit_dir[3];
   bit                 force_on;
   string              lane_name[3] = '{"new_vel_x", "new_vel_y", "new_vel_z"};

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, probe;
      r = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
         if (x >= r + probe) begin
            x -= r + probe;
            r = (r >> 1) + probe;
         end else begin
            r >>= 1;
         end
         probe >>= 2;
      end
      return r;
   endfunction

   // unit direction in Q1.16, zero vector or zero strength turns the force off
   function automatic void derive_direction();
      logic signed [16:0] comp;
      longint             ds;
      longint unsigned    mag[3];
      bit                 neg[3];
      longint unsigned    sum, len, u;
      int                 i;
      sum = 0;
      for (i = 0; i < 3; i++) begin
         comp = wind_dir[i];
         ds = comp;
         neg[i] = ds < 0;
         mag[i] = neg[i] ? -ds : ds;
         sum += mag[i] * mag[i];
      end
      if (sum == 0) begin
         for (i = 0; i < 3; i++) unit_dir[i] = 0;
         force_on = 1'b0;
         return;
      end
      len = root_floor(sum << 16);
      for (i = 0; i < 3; i++) begin
         u = ((mag[i] << 24) + len / 2) / len;
         if (u > UNIT_CLAMP) u = UNIT_CLAMP;
         unit_dir[i] = neg[i] ? -longint'(u) : longint'(u);
      end
      force_on = wind_strength != 0;
   endfunction

   function automatic void apply_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
         CSR_DIR_X:    wind_dir[0] = data[16:0];
         CSR_DIR_Y:    wind_dir[1] = data[16:0];
         CSR_DIR_Z:    wind_dir[2] = data[16:0];
         CSR_STRENGTH: wind_strength = data[15:0];
         CSR_GUST:     gust_amount = data[16:0];
         CSR_FRAME:    frame_number = data;
         default:      return;
      endcase
      derive_direction();
   endfunction

   function automatic logic [31:0] wang_mix(logic [31:0] s);
      s = (s ^ SEED_XOR) ^ (s >> 16);
      s = s + (s << 3);
      s = s ^ (s >> 4);
      s = s * SEED_MUL;
      s = s ^ (s >> 15);
      return s;
   endfunction

   function automatic wind_velocity_type predict_wind_velocity(logic [31:0] idx,
                                                               logic [2:0][VW-1:0] vel_in);
      wind_velocity_type     res;
      logic [31:0]           seed;
      longint unsigned       r, g, diff, q, gust, ua, p, mag;
      longint                v, d;
      logic signed [VW-1:0]  lane;
      int                    i;
      res.sat = 1'b0;
      seed = idx + frame_number * FRAME_STRIDE;
      r = wang_mix(seed) & HALF_RANGE;
      g = (gust_amount > GUST_UNITY) ? GUST_UNITY : gust_amount;
      diff = (2 * r >= HALF_RANGE) ? 2 * r - HALF_RANGE : HALF_RANGE - 2 * r;
      q = (2 * g * diff + HALF_RANGE) / (2 * HALF_RANGE);
      gust = (2 * r >= HALF_RANGE) ? GUST_UNITY + q : GUST_UNITY - q;
      for (i = 0; i < 3; i++) begin
         lane = vel_in[i];
         v = lane;
         if (force_on) begin
            ua = unit_dir[i] < 0 ? -unit_dir[i] : unit_dir[i];
            p = ua * wind_strength * gust;
            mag = (2 * p + FORCE_DIVISOR) / (2 * FORCE_DIVISOR);
            d = unit_dir[i] < 0 ? -longint'(mag) : longint'(mag);
            if (d > 0 && v > VEL_TOP - d) begin
               v = VEL_TOP;
               res.sat = 1'b1;
            end else if (d < 0 && v < VEL_BOTTOM - d) begin
               v = VEL_BOTTOM;
               res.sat = 1'b1;
            end else begin
               v += d;
            end
         end
         res.vel[i] = v[VW-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      wind_velocity_type  want, got;
      logic [2:0][VW-1:0] vin;
      int                 i;
      if (reset) begin
         wind_dir[0] = 17'd4096;
         wind_dir[1] = '0;
         wind_dir[2] = '0;
         wind_strength = 16'd4096;
         gust_amount = '0;
         frame_number = '0;
         derive_direction();
         expected_velocities.delete();
      end else begin
         if (csr_wen) apply_register(csr_index, csr_wdata);
         // results first: a request taken at this edge cannot leave at the same edge
         if (pop && !empty) begin
            got.vel[0] = rsp_new_vel_x;
            got.vel[1] = rsp_new_vel_y;
            got.vel[2] = rsp_new_vel_z;
            got.sat = rsp_saturated;
            if (expected_velocities.size() == 0) begin
               $error("result popped with no request pending");
               failures++;
            end else begin
               want = expected_velocities.pop_front();
               for (i = 0; i < 3; i++) begin
                  if (got.vel[i] !== want.vel[i]) begin
                     $error("%s: expected %0d, got %0d", lane_name[i],
                            $signed(want.vel[i]), $signed(got.vel[i]));
                     failures++;
                  end
               end
               if (got.sat !== want.sat) begin
                  $error("saturated: expected %0d, got %0d", want.sat, got.sat);
                  failures++;
               end
            end
         end
         if (push && !full) begin
            vin[0] = req_vel_x;
            vin[1] = req_vel_y;
            vin[2] = req_vel_z;
            expected_velocities.push_back(predict_wind_velocity(req_particle_index, vin));
         end
      end
      waiting = expected_velocities.size();
   end

endmodule

// ----- tb/sv/tb_particle_wind_velocity_update.sv -----
`timescale 1ns / 1ps

module tb_particle_wind_velocity_update;
   import pwv_pkg::*;

   localparam int VW          = 32;
   localparam int QUIET_LIMIT = 2000;
   localparam logic [VW-1:0] VEL_MAX = {1'b0, {(VW - 1){1'b1}}};
   localparam logic [VW-1:0] VEL_MIN = {1'b1, {(VW - 1){1'b0}}};
   // indexes past the register file, writes there must be dropped
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          push = 1'b0;
   logic          full;
   logic [31:0]   req_particle_index = '0;
   logic [VW-1:0] req_vel_x = '0;
   logic [VW-1:0] req_vel_y = '0;
   logic [VW-1:0] req_vel_z = '0;
   logic          empty;
   logic          pop = 1'b0;
   logic [VW-1:0] rsp_new_vel_x;
   logic [VW-1:0] rsp_new_vel_y;
   logic [VW-1:0] rsp_new_vel_z;
   logic          rsp_saturated;
   logic          csr_wen = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_wdata = '0;

   int unsigned   failures;
   int unsigned   waiting;
   int            send_idle_pct = 9;
   int            recv_stall_pct = 70;
   int            quiet_cycles = 0;

   particle_wind_velocity_update #(.VELOCITY_WIDTH(VW)) uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_particle_index(req_particle_index),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_vel_z(req_vel_z),
      .empty(empty), .pop(pop),
      .rsp_new_vel_x(rsp_new_vel_x), .rsp_new_vel_y(rsp_new_vel_y),
      .rsp_new_vel_z(rsp_new_vel_z), .rsp_saturated(rsp_saturated),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   particle_wind_checker #(.VW(VW)) u_checker (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_particle_index(req_particle_index),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_vel_z(req_vel_z),
      .empty(empty), .pop(pop),
      .rsp_new_vel_x(rsp_new_vel_x), .rsp_new_vel_y(rsp_new_vel_y),
      .rsp_new_vel_z(rsp_new_vel_z), .rsp_saturated(rsp_saturated),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .waiting(waiting)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= $urandom_range(0, 99) >= recv_stall_pct;
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || csr_wen) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // push stays high after acceptance so back-to-back requests need no extra edge
   task automatic send_particle(input logic [31:0] idx,
                                input logic [VW-1:0] vx, vy, vz);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_particle_index <= idx;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_vel_z <= vz;
      @(negedge clock);
      while (full) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic settle();
      push <= 1'b0;
      @(negedge clock);
      while (waiting != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic put_register(input logic [2:0] idx, input logic [31:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   function automatic logic [VW-1:0] pick_velocity();
      case ($urandom_range(0, 4))
         0:       return VEL_MAX - VW'($urandom_range(0, 65535));
         1:       return VEL_MIN + VW'($urandom_range(0, 65535));
         2:       return VW'($urandom_range(0, 131071)) - VW'(65536);
         default: return VW'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_direction();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return 32'd0;
         2:       return 32'h0000_FFFF;
         3:       return 32'h0001_0000;
         default: return 32'($urandom_range(0, 16384)) - 32'd8192;
      endcase
   endfunction

   task automatic program_random_wind();
      logic [31:0] value;
      if ($urandom_range(0, 2) != 0) put_register(CSR_DIR_X, pick_direction());
      if ($urandom_range(0, 2) != 0) put_register(CSR_DIR_Y, pick_direction());
      if ($urandom_range(0, 2) != 0) put_register(CSR_DIR_Z, pick_direction());
      if ($urandom_range(0, 11) == 0) begin
         put_register(CSR_DIR_X, 32'd0);
         put_register(CSR_DIR_Y, 32'd0);
         put_register(CSR_DIR_Z, 32'd0);
      end
      if ($urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 7))
            0:       value = 32'd0;
            1:       value = 32'h0000_FFFF;
            default: value = $urandom;
         endcase
         put_register(CSR_STRENGTH, value);
      end
      if ($urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 4))
            0:       value = 32'd0;
            1:       value = 32'd65536;
            2:       value = 32'h0001_FFFF;
            3:       value = $urandom_range(0, 131071);
            default: value = $urandom;
         endcase
         put_register(CSR_GUST, value);
      end
      if ($urandom_range(0, 2) != 0) put_register(CSR_FRAME, $urandom);
      if ($urandom_range(0, 7) == 0) begin
         put_register($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
      end
      csr_wen <= 1'b0;
   endtask

   initial begin
      logic [31:0] list_index;
      int          grp, ph, n;
      list_index = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default wind: +x at strength one, no gust
      send_particle(32'd0, '0, '0, '0);
      send_particle(32'hFFFF_FFFF, VEL_MAX, VEL_MIN, {VW{1'b1}});
      send_particle(32'd12345, VEL_MAX - VW'(100), VEL_MAX, VEL_MIN);
      send_particle(32'd1, VEL_MIN, pick_velocity(), pick_velocity());

      // extreme direction, full strength, gust past one, last frame
      settle();
      put_register(CSR_DIR_X, 32'h0001_0000);
      put_register(CSR_DIR_Y, 32'h0000_FFFF);
      put_register(CSR_DIR_Z, 32'h0001_0000);
      put_register(CSR_STRENGTH, 32'hFFFF_FFFF);
      put_register(CSR_GUST, 32'hFFFF_FFFF);
      put_register(CSR_FRAME, 32'hFFFF_FFFF);
      csr_wen <= 1'b0;
      send_particle(32'd0, VEL_MIN, VEL_MAX, '0);
      send_particle(32'hFFFF_FFFF, VEL_MIN + VW'(10), '0, VEL_MAX);
      send_particle(32'd7, pick_velocity(), pick_velocity(), pick_velocity());
      send_particle(32'd8, VEL_MAX, VEL_MIN, VEL_MIN);

      // gust exactly one, writes to unused indexes must change nothing
      settle();
      put_register(CSR_GUST, 32'd65536);
      put_register(CSR_FRAME, 32'd0);
      put_register(CSR_SPARE_LO, 32'hFFFF_FFFF);
      put_register(CSR_SPARE_HI, 32'h0000_0000);
      csr_wen <= 1'b0;
      send_particle(32'd2, pick_velocity(), pick_velocity(), pick_velocity());
      send_particle($urandom, pick_velocity(), pick_velocity(), pick_velocity());
      send_particle($urandom, VEL_MAX, VEL_MAX, VEL_MIN);

      // zero direction vector: pass-through
      settle();
      put_register(CSR_DIR_X, 32'd0);
      put_register(CSR_DIR_Y, 32'd0);
      put_register(CSR_DIR_Z, 32'd0);
      csr_wen <= 1'b0;
      send_particle(32'hFFFF_FFFF, VEL_MAX, VEL_MIN, VEL_MAX);
      send_particle(32'd0, VEL_MIN, VEL_MAX, '0);
      send_particle($urandom, pick_velocity(), pick_velocity(), pick_velocity());

      // zero strength with a real direction: pass-through
      settle();
      put_register(CSR_DIR_Z, 32'd4096);
      put_register(CSR_STRENGTH, 32'd0);
      csr_wen <= 1'b0;
      send_particle(32'd3, VEL_MAX, VEL_MIN, VEL_MAX);
      send_particle($urandom, pick_velocity(), pick_velocity(), pick_velocity());

      // smallest nonzero strength, no gust
      settle();
      put_register(CSR_STRENGTH, 32'd1);
      put_register(CSR_GUST, 32'd0);
      csr_wen <= 1'b0;
      send_particle(32'd4, '0, '0, VEL_MAX);
      send_particle($urandom, pick_velocity(), pick_velocity(), pick_velocity());

      for (grp = 0; grp < 3; grp++) begin
         case (grp)
            0: begin
               send_idle_pct = 9;
               recv_stall_pct = 70;
            end
            1: begin
               send_idle_pct = 70;
               recv_stall_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (ph = 0; ph < 8; ph++) begin
            settle();
            program_random_wind();
            for (n = 0; n < 65; n++) begin
               // mostly list order, as particles stream from memory
               if ($urandom_range(0, 3) != 0) list_index++;
               else list_index = $urandom;
               send_particle(list_index, pick_velocity(), pick_velocity(), pick_velocity());
            end
         end
      end

      push <= 1'b0;
      @(negedge clock);
      while (waiting != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && waiting == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
